// File: hdl/lwbc_pkg.sv
// Shared package for the LRU write-back block cache tag controller.
// Holds field widths, operation and status codes, register indexes and the cell control type.
// No dependencies.
`default_nettype none

package lwbc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 8;

  localparam int unsigned TAG_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS_FILLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MARKED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FLUSH_ENTRY = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FLUSH_DONE  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITABLE    = 2'd1;

  // Per-cell update request for one cycle.
  typedef struct packed {
    logic take;       // load the entry offered from above (or the top entry)
    logic clr_entry;  // clear valid and dirty
    logic clr_dirty;  // clear dirty only
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/lwbc_cell.sv
// One position of the LRU stack: tag, valid, dirty and buffer slot, plus tag compare.
// Depends on lwbc_pkg for the tag width and the cell control type.
`default_nettype none

module lwbc_cell #(
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned INDEX  = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lwbc_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [lwbc_pkg::TAG_W-1:0]  key_i,
  input  wire logic [lwbc_pkg::TAG_W-1:0]  in_tag_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_dirty_i,
  input  wire logic [SLOT_W-1:0]           in_slot_i,
  output logic      [lwbc_pkg::TAG_W-1:0]  tag_o,
  output logic                             valid_o,
  output logic                             dirty_o,
  output logic      [SLOT_W-1:0]           slot_o,
  output logic                             match_o
);

  logic [lwbc_pkg::TAG_W-1:0] tag_q;
  logic                       valid_q;
  logic                       dirty_q;
  logic [SLOT_W-1:0]          slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      slot_q  <= SLOT_W'(INDEX);
    end else if (ctrl_i.take) begin
      tag_q   <= in_tag_i;
      valid_q <= in_valid_i;
      dirty_q <= in_dirty_i;
      slot_q  <= in_slot_i;
    end else if (ctrl_i.clr_entry) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else if (ctrl_i.clr_dirty) begin
      dirty_q <= 1'b0;
    end
  end

  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign dirty_o = dirty_q;
  assign slot_o  = slot_q;
  assign match_o = valid_q && (tag_q == key_i);

endmodule

`default_nettype wire

// File: hdl/lru_writeback_block_cache_tags.sv
// Top level of the LRU write-back block cache tag controller: control sequencer and cell chain.
// Depends on lwbc_pkg and lwbc_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i and block_number_i. Output channel
//   (out_valid_o/out_ready_i) carries status_o, slot_o, writeback_needed_o, victim_block_o
//   and last_o. Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i):
//   index 0 is block_limit, index 1 is writable; other indexes are ignored.
//   Access and mark-dirty: the item is registered on acceptance, the tag compare in every
//   cell is registered in S_MATCH, and the stack shift and the result register load follow
//   in S_EXEC, which holds while the result register is full and not read. No new item is
//   accepted until the current one is done; the compare and shift across the cells set this pace.
//   Flush: one result per dirty entry, from most to least recent, then a done result; each
//   result is held back while the receiver stalls. A read-only flush gives only the
//   done result.
//   The result register lets the next item be accepted while a result still waits. A
//   stalled receiver holds the sequencer before the stack update, so no result is lost.
//   Reset: all entries invalid and clean, position i holds slot i, registers cleared.
//   There is no clearing pass.
`default_nettype none

module lru_writeback_block_cache_tags #(
  parameter int unsigned CACHE_ENTRIES = lwbc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [lwbc_pkg::OP_W-1:0]          op_i,
  input  wire logic [lwbc_pkg::TAG_W-1:0]         block_number_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [lwbc_pkg::STATUS_W-1:0]      status_o,
  output logic      [lwbc_pkg::SLOT_OUT_W-1:0]    slot_o,
  output logic                                    writeback_needed_o,
  output logic      [lwbc_pkg::TAG_W-1:0]         victim_block_o,
  output logic                                    last_o
);

  localparam int unsigned N      = CACHE_ENTRIES;
  localparam int unsigned SLOT_W = $clog2(N);
  localparam int unsigned TAG_W  = lwbc_pkg::TAG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC,
    S_FLUSH
  } state_e;

  state_e                         state_q, state_d;
  logic [lwbc_pkg::OP_W-1:0]      op_q;
  logic [TAG_W-1:0]               blk_q;
  logic [N-1:0]                   match_q;
  logic [TAG_W-1:0]               limit_q;
  logic                           writable_q;

  logic                           out_valid_q;
  logic [lwbc_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [lwbc_pkg::SLOT_OUT_W-1:0] slot_q, slot_d;
  logic                           wb_q, wb_d;
  logic [TAG_W-1:0]               victim_q, victim_d;
  logic                           last_q, last_d;
  logic                           load_out;
  logic                           out_free;

  // Cell chain view
  logic [TAG_W-1:0]   cell_tag   [N];
  logic               cell_valid [N];
  logic               cell_dirty [N];
  logic [SLOT_W-1:0]  cell_slot  [N];
  logic [N-1:0]       match_v;
  logic [N-1:0]       dirty_v;

  logic [N-1:0]       take_v, clre_v, clrd_v;
  logic [N-1:0]       pvec, above, hi_oh, ge;

  logic [TAG_W-1:0]   sel_tag;
  logic               sel_valid;
  logic               sel_dirty;
  logic [SLOT_W-1:0]  sel_slot;

  logic [TAG_W-1:0]   top_tag;
  logic               top_valid;
  logic               top_dirty;
  logic [SLOT_W-1:0]  top_slot;

  logic [SLOT_W-1:0]  out_slot_n;
  logic [SLOT_W+lwbc_pkg::SLOT_OUT_W-1:0] out_slot_ext;

  logic               hit;
  logic               flush_any;

  // Highest set bit of the priority vector: newest match, or newest dirty entry while flushing
  assign pvec = (state_q == S_FLUSH) ? dirty_v : match_q;

  for (genvar i = 0; i < N; i++) begin : g_prio
    assign above[i] = |(pvec >> (i + 1));
    assign hi_oh[i] = pvec[i] & ~above[i];
    assign ge[i]    = |(hi_oh << (N - 1 - i));
  end

  assign hit       = |match_q;
  assign flush_any = writable_q && (|dirty_v);

  always_comb begin
    sel_tag   = '0;
    sel_valid = 1'b0;
    sel_dirty = 1'b0;
    sel_slot  = '0;
    for (int i = 0; i < N; i++) begin
      sel_tag   = sel_tag   | (cell_tag[i] & {TAG_W{hi_oh[i]}});
      sel_valid = sel_valid | (cell_valid[i] & hi_oh[i]);
      sel_dirty = sel_dirty | (cell_dirty[i] & hi_oh[i]);
      sel_slot  = sel_slot  | (cell_slot[i] & {SLOT_W{hi_oh[i]}});
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    load_out   = 1'b0;
    take_v     = '0;
    clre_v     = '0;
    clrd_v     = '0;
    top_tag    = sel_tag;
    top_valid  = sel_valid;
    top_dirty  = sel_dirty;
    top_slot   = sel_slot;
    status_d   = status_q;
    out_slot_n = '0;
    wb_d       = 1'b0;
    victim_d   = '0;
    last_d     = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            lwbc_pkg::OP_ACCESS, lwbc_pkg::OP_MARK: state_d = S_MATCH;
            lwbc_pkg::OP_FLUSH:                     state_d = S_FLUSH;
            default:                                state_d = S_IDLE;
          endcase
        end
      end

      S_MATCH: state_d = S_EXEC;

      S_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
          if (hit) begin
            // promote the newest match to the top
            take_v     = ge;
            top_dirty  = sel_dirty | (op_q == lwbc_pkg::OP_MARK);
            out_slot_n = sel_slot;
            status_d   = (op_q == lwbc_pkg::OP_MARK) ? lwbc_pkg::ST_MARKED : lwbc_pkg::ST_HIT;
          end else if (op_q == lwbc_pkg::OP_MARK) begin
            status_d = lwbc_pkg::ST_NOT_FOUND;
          end else begin
            wb_d       = cell_valid[0] && cell_dirty[0];
            victim_d   = (cell_valid[0] && cell_dirty[0]) ? cell_tag[0] : '0;
            out_slot_n = cell_slot[0];
            if (blk_q >= limit_q) begin
              clre_v[0] = 1'b1;
              status_d  = lwbc_pkg::ST_OUT_RANGE;
            end else begin
              // retag the bottom entry and rotate it to the top
              take_v    = '1;
              top_tag   = blk_q;
              top_valid = 1'b1;
              top_dirty = 1'b0;
              top_slot  = cell_slot[0];
              status_d  = lwbc_pkg::ST_MISS_FILLED;
            end
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (flush_any) begin
            clrd_v     = hi_oh;
            out_slot_n = sel_slot;
            victim_d   = sel_tag;
            last_d     = 1'b0;
            status_d   = lwbc_pkg::ST_FLUSH_ENTRY;
          end else begin
            status_d = lwbc_pkg::ST_FLUSH_DONE;
            state_d  = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_slot_ext = {{lwbc_pkg::SLOT_OUT_W{1'b0}}, out_slot_n};
  assign slot_d       = out_slot_ext[lwbc_pkg::SLOT_OUT_W-1:0];

  // Sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= lwbc_pkg::OP_ACCESS;
      blk_q       <= '0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= lwbc_pkg::ST_HIT;
      slot_q      <= '0;
      wb_q        <= 1'b0;
      victim_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) begin
        op_q  <= op_i;
        blk_q <= block_number_i;
      end
      if (state_q == S_MATCH) begin
        match_q <= match_v;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        slot_q      <= slot_d;
        wb_q        <= wb_d;
        victim_q    <= victim_d;
        last_q      <= last_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= '0;
      writable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lwbc_pkg::CFG_BLOCK_LIMIT: limit_q    <= cfg_data_i[TAG_W-1:0];
        lwbc_pkg::CFG_WRITABLE:    writable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Cell chain: each cell takes from the one above; the top cell takes the promoted entry
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [TAG_W-1:0]     nt;
    logic                 nv;
    logic                 nd;
    logic [SLOT_W-1:0]    ns;
    lwbc_pkg::cell_ctrl_t ctrl;

    if (i == N - 1) begin : g_top
      assign nt = top_tag;
      assign nv = top_valid;
      assign nd = top_dirty;
      assign ns = top_slot;
    end else begin : g_mid
      assign nt = cell_tag[i+1];
      assign nv = cell_valid[i+1];
      assign nd = cell_dirty[i+1];
      assign ns = cell_slot[i+1];
    end

    assign ctrl.take      = take_v[i];
    assign ctrl.clr_entry = clre_v[i];
    assign ctrl.clr_dirty = clrd_v[i];

    lwbc_cell #(
      .SLOT_W (SLOT_W),
      .INDEX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_i      (blk_q),
      .in_tag_i   (nt),
      .in_valid_i (nv),
      .in_dirty_i (nd),
      .in_slot_i  (ns),
      .tag_o      (cell_tag[i]),
      .valid_o    (cell_valid[i]),
      .dirty_o    (cell_dirty[i]),
      .slot_o     (cell_slot[i]),
      .match_o    (match_v[i])
    );

    assign dirty_v[i] = cell_dirty[i];
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign slot_o             = slot_q;
  assign writeback_needed_o = wb_q;
  assign victim_block_o     = victim_q;
  assign last_o             = last_q;

`ifndef SYNTHESIS
  a_lookup_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == lwbc_pkg::OP_ACCESS || op_i == lwbc_pkg::OP_MARK))
    |-> ##2 (state_q == S_EXEC))
    else $error("lookup did not reach the update step two cycles after acceptance");

  a_flush_cleans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && status_d == lwbc_pkg::ST_FLUSH_ENTRY)
    |=> ($countones(dirty_v) + 1 == $past($countones(dirty_v))))
    else $error("flushed entry did not lose exactly one dirty bit");

  a_single_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hi_oh))
    else $error("more than one cell selected for promotion or flush");
`endif

endmodule

`default_nettype wire
